>>> rtl/tsst_pkg.sv
// ----------------------------------------------------------------------------
// tsst_pkg
// Shared widths, request and status codes and the register set of the tab
// stop table.
// ----------------------------------------------------------------------------
package tsst_pkg;

  localparam int MAX_STOPS  = 128;

  localparam int REQ_W      = 3;
  localparam int COL_W      = 7;
  localparam int NTH_W      = 8;
  localparam int POS_W      = 8;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TW_W       = 7;
  localparam int DC_W       = 8;
  localparam int LW_W       = 8;

  // highest column a stop may take
  localparam logic [DC_W-1:0] COL_LIMIT = 8'd127;

  localparam logic [REQ_W-1:0] REQ_DEFAULTS = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_NEXT     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PREV     = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_SAME = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd2;

  localparam logic [TW_W-1:0] TAB_WIDTH_RST     = 7'd8;
  localparam logic [DC_W-1:0] DEFAULT_COUNT_RST = 8'd16;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST    = 8'd80;

  typedef struct packed {
    logic [TW_W-1:0] tab_width;
    logic [DC_W-1:0] default_count;
    logic [LW_W-1:0] line_width;
  } cfg_t;

endpackage

>>> rtl/tsst_ram.sv
// ----------------------------------------------------------------------------
// tsst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsst_ram #(
  parameter int WIDTH = tsst_pkg::COL_W,
  parameter int DEPTH = tsst_pkg::MAX_STOPS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/tsst_cfg.sv
// ----------------------------------------------------------------------------
// tsst_cfg
// Configuration registers: tab width, default stop count and line width.
// ----------------------------------------------------------------------------
module tsst_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsst_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tsst_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_width     <= tsst_pkg::TAB_WIDTH_RST;
      cfg.default_count <= tsst_pkg::DEFAULT_COUNT_RST;
      cfg.line_width    <= tsst_pkg::LINE_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsst_pkg::CFG_TAB_WIDTH: begin
          cfg.tab_width <= cfg_data[tsst_pkg::TW_W-1:0];
        end
        tsst_pkg::CFG_DEFAULT_COUNT: begin
          cfg.default_count <= cfg_data;
        end
        tsst_pkg::CFG_LINE_WIDTH: begin
          cfg.line_width <= cfg_data;
        end
        default: begin
          // writes beyond the register set are dropped
        end
      endcase
    end
  end

endmodule

>>> rtl/tsst_seq.sv
// ----------------------------------------------------------------------------
// tsst_seq
// Request sequencer: scans the stop memory, shifts entries on insert and
// remove, fetches search answers and sweeps in the default stops.
// ----------------------------------------------------------------------------
module tsst_seq #(
  parameter int MAX_STOPS = tsst_pkg::MAX_STOPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tsst_pkg::REQ_W-1:0]        req_type,
  input  logic [tsst_pkg::COL_W-1:0]        column,
  input  logic [tsst_pkg::NTH_W-1:0]        nth,
  input  tsst_pkg::cfg_t                    cfg,
  output logic                              strobe,
  output logic [tsst_pkg::POS_W-1:0]        position,
  output logic [tsst_pkg::ST_W-1:0]         status,
  output logic [$clog2(MAX_STOPS)-1:0]      rd_addr,
  input  logic [tsst_pkg::COL_W-1:0]        rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_STOPS)-1:0]      wr_addr,
  output logic [tsst_pkg::COL_W-1:0]        wr_data
);

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam int SW = ((CW > tsst_pkg::NTH_W) ? CW : tsst_pkg::NTH_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_SHUP  = 8'b0000_1000,
    S_PUT   = 8'b0001_0000,
    S_SHDN  = 8'b0010_0000,
    S_FETCH = 8'b0100_0000,
    S_DEF   = 8'b1000_0000
  } state_t;

  state_t                       state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [tsst_pkg::REQ_W-1:0]   req;
  logic [tsst_pkg::COL_W-1:0]   col;
  logic [tsst_pkg::NTH_W-1:0]   nm1;
  logic [AW-1:0]                scan_idx;
  logic [CW-1:0]                idx;
  logic                         hit;
  logic [tsst_pkg::COL_W-1:0]   hit_q;
  logic [AW-1:0]                sh;
  logic [CW-1:0]                def_i;
  logic [tsst_pkg::DC_W-1:0]    def_acc;

  logic                         accept;
  logic                         fin;
  logic [tsst_pkg::POS_W-1:0]   fin_pos;
  logic [tsst_pkg::ST_W-1:0]    fin_st;
  logic                         scan_hit, scan_last;
  logic                         same_col, full;
  logic [CW-1:0]                count_m1, prev_i;
  logic [SW-1:0]                tgt, prev_addr;
  logic                         next_ok, prev_ok, def_go;
  logic [tsst_pkg::POS_W-1:0]   fallback;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // next search looks for the first stop above the column, the rest for the
  // first stop at or above it
  assign scan_hit  = (req == tsst_pkg::REQ_NEXT) ? (rd_data > col) : (rd_data >= col);
  assign scan_last = (CW'(scan_idx) + CW'(1)) == count;

  assign count_m1  = count - CW'(1);
  assign same_col  = hit && (hit_q == col);
  assign full      = (count == CW'(MAX_STOPS));
  assign tgt       = SW'(idx) + SW'(nm1);
  assign next_ok   = hit && (tgt < SW'(count));
  assign prev_i    = idx - CW'(1);
  assign prev_ok   = (idx != '0) && (SW'(nm1) <= SW'(prev_i));
  assign prev_addr = SW'(prev_i) - SW'(nm1);
  assign fallback  = (cfg.line_width != '0) ? (cfg.line_width - 8'd1) : '0;
  assign def_go    = (SW'(def_i) < SW'(cfg.default_count)) &&
                     (def_i < CW'(MAX_STOPS)) &&
                     (def_acc <= tsst_pkg::COL_LIMIT);

  always_comb begin
    state_next = state;
    count_next = count;
    fin        = 1'b0;
    fin_pos    = '0;
    fin_st     = tsst_pkg::ST_DONE;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            tsst_pkg::REQ_DEFAULTS: begin
              state_next = S_DEF;
            end
            tsst_pkg::REQ_CLEAR: begin
              count_next = '0;
              fin        = 1'b1;
            end
            tsst_pkg::REQ_INSERT, tsst_pkg::REQ_REMOVE,
            tsst_pkg::REQ_NEXT, tsst_pkg::REQ_PREV: begin
              state_next = (count == '0) ? S_EVAL : S_SCAN;
            end
            default: begin
              fin    = 1'b1;
              fin_st = tsst_pkg::ST_SAME;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = scan_idx + AW'(1);
        if (scan_hit || scan_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (req)
          tsst_pkg::REQ_INSERT: begin
            if (same_col) begin
              fin    = 1'b1;
              fin_st = tsst_pkg::ST_SAME;
            end else if (full) begin
              fin    = 1'b1;
              fin_st = tsst_pkg::ST_FULL;
            end else if (idx == count) begin
              state_next = S_PUT;
            end else begin
              rd_addr    = count_m1[AW-1:0];
              state_next = S_SHUP;
            end
          end
          tsst_pkg::REQ_REMOVE: begin
            if (!same_col) begin
              fin    = 1'b1;
              fin_st = tsst_pkg::ST_SAME;
            end else if (idx == count_m1) begin
              count_next = count_m1;
              fin        = 1'b1;
            end else begin
              rd_addr    = idx[AW-1:0] + AW'(1);
              state_next = S_SHDN;
            end
          end
          tsst_pkg::REQ_NEXT: begin
            if (next_ok) begin
              rd_addr    = tgt[AW-1:0];
              state_next = S_FETCH;
            end else begin
              fin     = 1'b1;
              fin_pos = fallback;
            end
          end
          tsst_pkg::REQ_PREV: begin
            if (prev_ok) begin
              rd_addr    = prev_addr[AW-1:0];
              state_next = S_FETCH;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = tsst_pkg::ST_SAME;
          end
        endcase
      end
      S_SHUP: begin
        // move entry sh up by one, reading the one below it meanwhile
        wr_en   = 1'b1;
        wr_addr = sh + AW'(1);
        wr_data = rd_data;
        if (sh == idx[AW-1:0]) begin
          state_next = S_PUT;
        end else begin
          rd_addr = sh - AW'(1);
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = idx[AW-1:0];
        wr_data    = col;
        count_next = count + CW'(1);
        fin        = 1'b1;
      end
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = sh - AW'(1);
        wr_data = rd_data;
        if (CW'(sh) == count_m1) begin
          count_next = count_m1;
          fin        = 1'b1;
        end else begin
          rd_addr = sh + AW'(1);
        end
      end
      S_FETCH: begin
        fin     = 1'b1;
        fin_pos = tsst_pkg::POS_W'(rd_data);
      end
      S_DEF: begin
        if (def_go) begin
          wr_en   = 1'b1;
          wr_addr = def_i[AW-1:0];
          wr_data = def_acc[tsst_pkg::COL_W-1:0];
        end else begin
          count_next = def_i;
          fin        = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      position <= fin_pos;
      status   <= fin_st;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          req      <= req_type;
          col      <= column;
          nm1      <= (nth == '0) ? '0 : (nth - 8'd1);
          scan_idx <= '0;
          idx      <= '0;
          hit      <= 1'b0;
          def_i    <= '0;
          def_acc  <= '0;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          idx   <= CW'(scan_idx);
          hit   <= 1'b1;
          hit_q <= rd_data;
        end else if (scan_last) begin
          idx <= count;
        end else begin
          scan_idx <= scan_idx + AW'(1);
        end
      end
      S_EVAL: begin
        sh <= rd_addr;
      end
      S_SHUP: begin
        sh <= sh - AW'(1);
      end
      S_SHDN: begin
        sh <= sh + AW'(1);
      end
      S_DEF: begin
        if (def_go) begin
          def_i   <= def_i + CW'(1);
          def_acc <= def_acc + {1'b0, cfg.tab_width};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tab_stop_table.sv
// ----------------------------------------------------------------------------
// tab_stop_table
// Sorted table of console tab stops held in a single-port-read stop memory.
// One request at a time; busy stays high until the result strobe is issued.
// Clear and unknown requests answer next cycle; results are never held off.
// Synchronous reset empties the table and loads the register defaults.
// ----------------------------------------------------------------------------
module tab_stop_table #(
  parameter int MAX_STOPS = tsst_pkg::MAX_STOPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [tsst_pkg::REQ_W-1:0]        req_type,
  input  logic [tsst_pkg::COL_W-1:0]        column,
  input  logic [tsst_pkg::NTH_W-1:0]        nth,
  output logic                              strobe,
  output logic [tsst_pkg::POS_W-1:0]        position,
  output logic [tsst_pkg::ST_W-1:0]         status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsst_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_STOPS);

  tsst_pkg::cfg_t              cfg;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [tsst_pkg::COL_W-1:0]  rd_data, wr_data;
  logic                        wr_en;

  tsst_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsst_ram #(
    .WIDTH (tsst_pkg::COL_W),
    .DEPTH (MAX_STOPS)
  ) u_stops (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tsst_seq #(
    .MAX_STOPS (MAX_STOPS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .column   (column),
    .nth      (nth),
    .cfg      (cfg),
    .strobe   (strobe),
    .position (position),
    .status   (status),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // every accepted word is either still in progress or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || strobe))
    else $error("accepted request neither in progress nor answered");

  // leaving the busy phase always comes with a result word
  a_finish_strobe: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe)
    else $error("request finished without a result");

  // only a completed search carries a position
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status != tsst_pkg::ST_DONE)) |-> (position == '0))
    else $error("position set on a request that did not complete");

endmodule
